// ----- sv/multi_led_blink_controller_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef MULTI_LED_BLINK_CONTROLLER_MACROS_SVH
`define MULTI_LED_BLINK_CONTROLLER_MACROS_SVH

// Check a property on every rising clock edge outside of reset.
`define MLBC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check that an expression never holds outside of reset.
`define MLBC_ASSERT_NEVER(label, expr, msg) \
  `MLBC_ASSERT(label, !(expr), msg)

`endif

// ----- sv/mlbc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package mlbc_pkg;

  // Channel modes
  typedef enum logic [1:0] {
    MODE_OFF    = 2'd0,
    MODE_ON     = 2'd1,
    MODE_SINGLE = 2'd2,
    MODE_CONT   = 2'd3
  } led_mode_e;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMD,
    ST_SCAN,
    ST_FLUSH
  } ctrl_state_e;

  // Item kinds
  localparam logic FUNC_CMD  = 1'b0;
  localparam logic FUNC_SCAN = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ON_BRIGHT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_PERIOD  = 2'd1;
  localparam int unsigned CFG_DATA_W = 16;

  // Reset values of the configuration registers
  localparam logic [7:0]  ON_BRIGHT_RST    = 8'd150;
  localparam logic [15:0] BLINK_PERIOD_RST = 16'd500;

  // Results per scan
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned RES_CNT_W   = 5;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;      // capture the input word
    logic cmd_exec;  // apply a mode command
    logic scan_run;  // step the channel scan
    logic flush;     // emit the held scan result as the final one
  } ctrl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic scan_done;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- sv/mlbc_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mlbc_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  input  logic                   func_i,
  input  mlbc_pkg::dp_status_t   status_i,
  output mlbc_pkg::ctrl_cmd_t    cmd_o,
  output logic                   busy
);

  mlbc_pkg::ctrl_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mlbc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mlbc_pkg::ST_IDLE: begin
        if (start) begin
          state_d = (func_i == mlbc_pkg::FUNC_SCAN) ? mlbc_pkg::ST_SCAN : mlbc_pkg::ST_CMD;
        end
      end
      mlbc_pkg::ST_CMD: begin
        state_d = mlbc_pkg::ST_IDLE;
      end
      mlbc_pkg::ST_SCAN: begin
        if (status_i.scan_done) begin
          state_d = mlbc_pkg::ST_FLUSH;
        end
      end
      mlbc_pkg::ST_FLUSH: begin
        state_d = mlbc_pkg::ST_IDLE;
      end
      default: begin
        state_d = mlbc_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o = '0;
    busy  = 1'b1;
    unique case (state_q)
      mlbc_pkg::ST_IDLE: begin
        busy       = 1'b0;
        cmd_o.load = start;
      end
      mlbc_pkg::ST_CMD: begin
        cmd_o.cmd_exec = 1'b1;
      end
      mlbc_pkg::ST_SCAN: begin
        cmd_o.scan_run = 1'b1;
      end
      mlbc_pkg::ST_FLUSH: begin
        cmd_o.flush = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/mlbc_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mlbc_dp #(
  parameter int unsigned NUM_LEDS = 16,
  parameter int unsigned CH_W     = 4,
  parameter int unsigned CNT_W    = 5
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  mlbc_pkg::ctrl_cmd_t                 cmd_i,
  output mlbc_pkg::dp_status_t                status_o,
  input  logic [3:0]                          led_index_i,
  input  logic [1:0]                          mode_i,
  input  logic [31:0]                         now_ms_i,
  input  logic                                cfg_valid_i,
  input  logic [mlbc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [mlbc_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output logic                                result_valid_o,
  output logic [3:0]                          out_led_o,
  output logic [7:0]                          brightness_o,
  output logic                                last_o
);

  localparam logic [CNT_W-1:0] LastCnt = CNT_W'(NUM_LEDS);
  localparam logic [6:0]       NumLeds7 = 7'(NUM_LEDS);
  localparam logic [mlbc_pkg::RES_CNT_W-1:0] MaxRes =
    mlbc_pkg::RES_CNT_W'(mlbc_pkg::MAX_RESULTS);

  // Configuration
  logic [7:0]  on_bright_q;
  logic [15:0] period_q;

  // Captured input word
  logic [3:0]          idx_q;
  mlbc_pkg::led_mode_e mode_q;
  logic [31:0]         now_q;

  // Per-channel state
  mlbc_pkg::led_mode_e mode_arr_q [NUM_LEDS];
  logic                tog_q      [NUM_LEDS];
  logic                st_vld_q   [NUM_LEDS];
  logic [31:0]         st_mem     [NUM_LEDS];

  // Scan pipeline
  logic [CNT_W-1:0] rd_cnt_q;
  logic             ev_vld_q;
  logic [CH_W-1:0]  ev_ch_q;
  logic [31:0]      rd_data_q;
  logic             rd_vld_q;

  // Held scan result
  logic                           pend_vld_q;
  logic [CH_W-1:0]                pend_ch_q;
  logic [7:0]                     pend_lvl_q;
  logic [mlbc_pkg::RES_CNT_W-1:0] res_cnt_q;

  // Output word
  logic       out_vld_q, out_vld_d;
  logic [3:0] out_led_q, out_led_d;
  logic [7:0] out_bri_q, out_bri_d;
  logic       out_last_q, out_last_d;

  logic [CH_W-1:0]     idx_ch;
  logic                idx_ok;
  logic [CH_W-1:0]     rd_ch;
  logic                issue;
  logic [31:0]         start_val;
  logic [31:0]         elapsed;
  logic                due;
  mlbc_pkg::led_mode_e ev_mode;
  logic                ev_tog;
  logic                ev_single;
  logic                ev_cont;
  logic [7:0]          ev_lvl;
  logic                capture;
  logic                cmd_timed;
  logic                st_we;
  logic [CH_W-1:0]     st_waddr;

  assign idx_ch = CH_W'(idx_q);
  assign idx_ok = 7'(idx_q) < NumLeds7;
  assign rd_ch  = rd_cnt_q[CH_W-1:0];
  assign issue  = cmd_i.scan_run && (rd_cnt_q != LastCnt);

  // Evaluate the channel whose start time was read last cycle
  assign start_val = rd_vld_q ? rd_data_q : 32'd0;
  assign elapsed   = now_q - start_val;
  assign due       = elapsed >= {16'd0, period_q};
  assign ev_mode   = mode_arr_q[ev_ch_q];
  assign ev_tog    = tog_q[ev_ch_q];
  assign ev_single = ev_vld_q && due && (ev_mode == mlbc_pkg::MODE_SINGLE);
  assign ev_cont   = ev_vld_q && due && (ev_mode == mlbc_pkg::MODE_CONT);
  assign ev_lvl    = (ev_cont && !ev_tog) ? on_bright_q : 8'd0;
  assign capture   = (ev_single || ev_cont) && (res_cnt_q != MaxRes);

  // Start time write port: a timed command or a toggling channel
  assign cmd_timed = cmd_i.cmd_exec && idx_ok &&
                     ((mode_q == mlbc_pkg::MODE_SINGLE) || (mode_q == mlbc_pkg::MODE_CONT));
  assign st_we     = cmd_timed || ev_cont;
  assign st_waddr  = cmd_i.cmd_exec ? idx_ch : ev_ch_q;

  assign status_o.scan_done = (rd_cnt_q == LastCnt) && !ev_vld_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_bright_q <= mlbc_pkg::ON_BRIGHT_RST;
      period_q    <= mlbc_pkg::BLINK_PERIOD_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        mlbc_pkg::CFG_ON_BRIGHT:    on_bright_q <= cfg_data_i[7:0];
        mlbc_pkg::CFG_BLINK_PERIOD: period_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Capture the input word
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      idx_q  <= led_index_i;
      mode_q <= mlbc_pkg::led_mode_e'(mode_i);
      now_q  <= now_ms_i;
    end
  end

  // Start time memory with registered read
  always_ff @(posedge clk_i) begin
    if (st_we) begin
      st_mem[st_waddr] <= now_q;
    end
    if (issue) begin
      rd_data_q <= st_mem[rd_ch];
      rd_vld_q  <= st_vld_q[rd_ch];
    end
  end

  // Channel mode, toggle level and start time valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_arr_q <= '{default: mlbc_pkg::MODE_OFF};
      tog_q      <= '{default: 1'b0};
      st_vld_q   <= '{default: 1'b0};
    end else begin
      if (st_we) begin
        st_vld_q[st_waddr] <= 1'b1;
      end
      if (cmd_i.cmd_exec && idx_ok) begin
        mode_arr_q[idx_ch] <= mode_q;
        if (mode_q == mlbc_pkg::MODE_CONT) begin
          tog_q[idx_ch] <= 1'b1;
        end
      end
      if (ev_single) begin
        mode_arr_q[ev_ch_q] <= mlbc_pkg::MODE_OFF;
      end
      if (ev_cont) begin
        tog_q[ev_ch_q] <= !ev_tog;
      end
    end
  end

  // Scan sequencing and held result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_cnt_q   <= '0;
      ev_vld_q   <= 1'b0;
      pend_vld_q <= 1'b0;
      res_cnt_q  <= '0;
    end else if (cmd_i.load) begin
      rd_cnt_q   <= '0;
      ev_vld_q   <= 1'b0;
      pend_vld_q <= 1'b0;
      res_cnt_q  <= '0;
    end else begin
      if (cmd_i.scan_run) begin
        ev_vld_q <= issue;
        if (issue) begin
          rd_cnt_q <= rd_cnt_q + CNT_W'(1);
        end
        if (capture) begin
          pend_vld_q <= 1'b1;
          res_cnt_q  <= res_cnt_q + mlbc_pkg::RES_CNT_W'(1);
        end
      end
      if (cmd_i.flush) begin
        pend_vld_q <= 1'b0;
      end
    end
  end

  // Held result payload
  always_ff @(posedge clk_i) begin
    if (issue) begin
      ev_ch_q <= rd_ch;
    end
    if (cmd_i.scan_run && capture) begin
      pend_ch_q  <= ev_ch_q;
      pend_lvl_q <= ev_lvl;
    end
  end

  // Select the next output word
  always_comb begin
    out_vld_d  = 1'b0;
    out_led_d  = out_led_q;
    out_bri_d  = out_bri_q;
    out_last_d = out_last_q;
    priority if (cmd_i.cmd_exec && idx_ok) begin
      out_vld_d  = 1'b1;
      out_led_d  = idx_q;
      out_bri_d  = (mode_q == mlbc_pkg::MODE_OFF) ? 8'd0 : on_bright_q;
      out_last_d = 1'b1;
    end else if (cmd_i.scan_run && capture && pend_vld_q) begin
      out_vld_d  = 1'b1;
      out_led_d  = 4'(pend_ch_q);
      out_bri_d  = pend_lvl_q;
      out_last_d = 1'b0;
    end else if (cmd_i.flush && pend_vld_q) begin
      out_vld_d  = 1'b1;
      out_led_d  = 4'(pend_ch_q);
      out_bri_d  = pend_lvl_q;
      out_last_d = 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_led_q  <= out_led_d;
    out_bri_q  <= out_bri_d;
    out_last_q <= out_last_d;
  end

  assign result_valid_o = out_vld_q;
  assign out_led_o      = out_led_q;
  assign brightness_o   = out_bri_q;
  assign last_o         = out_last_q;

endmodule

`default_nettype wire

// ----- sv/multi_led_blink_controller.sv -----
// Channel   | Direction | Handshake                  | Word
// ----------+-----------+----------------------------+--------------------------------------
// item      | in        | start, busy                | func, led_index, mode, now_ms
// result    | out       | result_valid_o (strobe)    | out_led, brightness, last
// config    | in        | cfg_valid_i, cfg_ready_o   | cfg_index_i, cfg_data_i
//
// A mode command holds busy through the CMD state; its word shows once busy drops.
// A scan holds busy for one start time read per channel, then evaluate, drain and emit
// the final word if a change is held; that word shows once busy drops.
// A change found by a scan is held until the next change or the final word pushes it out.
// Reset clears all channels to off with a zero start time and restores the registers.
// The receiver cannot stall; configuration writes are always taken.
`timescale 1ns / 1ps
`default_nettype none

module multi_led_blink_controller #(
  parameter int unsigned NUM_LEDS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic                                func_i,
  input  logic [3:0]                          led_index_i,
  input  logic [1:0]                          mode_i,
  input  logic [31:0]                         now_ms_i,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [mlbc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [mlbc_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output logic                                result_valid_o,
  output logic [3:0]                          out_led_o,
  output logic [7:0]                          brightness_o,
  output logic                                last_o
);

  localparam int unsigned CH_W  = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
  localparam int unsigned CNT_W = $clog2(NUM_LEDS + 1);

  mlbc_pkg::ctrl_cmd_t  cmd;
  mlbc_pkg::dp_status_t status;

  assign cfg_ready_o = 1'b1;

  mlbc_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .func_i   (func_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  mlbc_dp #(
    .NUM_LEDS (NUM_LEDS),
    .CH_W     (CH_W),
    .CNT_W    (CNT_W)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .led_index_i    (led_index_i),
    .mode_i         (mode_i),
    .now_ms_i       (now_ms_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .out_led_o      (out_led_o),
    .brightness_o   (brightness_o),
    .last_o         (last_o)
  );

endmodule

`default_nettype wire

// ----- sv/mlbc_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "multi_led_blink_controller_macros.svh"

module mlbc_checker #(
  parameter int unsigned NUM_LEDS = 16
) (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                start,
  input logic                                busy,
  input logic                                func_i,
  input logic [3:0]                          led_index_i,
  input logic                                result_valid_o,
  input logic [3:0]                          out_led_o,
  input logic                                last_o
);

  logic cmd_take;
  logic res_last;

  // Flag a command on an existing channel and a final word on the result port
  assign cmd_take = start && !busy && (func_i == mlbc_pkg::FUNC_CMD) &&
                    (7'(led_index_i) < 7'(NUM_LEDS));
  assign res_last = result_valid_o && last_o;

  // An accepted item occupies the block in the following cycle
  `MLBC_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted item did not raise busy")

  // A command on an existing channel answers through the CMD state and the output register, as the final word
  `MLBC_ASSERT(a_cmd_result,
    cmd_take |-> ##2 (res_last && out_led_o == $past(led_index_i, 2)),
    "command result missing or wrong channel")

  // No word appears while busy is low and was already low in the previous cycle
  `MLBC_ASSERT_NEVER(a_idle_quiet, result_valid_o && !busy && !$past(busy), "result while idle")

  // No word follows straight after the final word of an item
  `MLBC_ASSERT(a_last_gap, res_last |=> !result_valid_o, "result right after final word")

endmodule

bind multi_led_blink_controller mlbc_checker #(.NUM_LEDS(NUM_LEDS)) u_mlbc_checker (.*);

`default_nettype wire

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned LED_COUNT = 16;
  localparam int unsigned MAX_ERR_LINES = 40;

  // One input word: a mode command for one channel or a timed scan
  typedef struct packed {
    logic                si_func;
    logic [3:0]          led;
    mlbc_pkg::led_mode_e mode;
    logic [31:0]         now;
  } led_item_t;

  // One brightness write seen on the result port
  typedef struct packed {
    logic [3:0] led;
    logic [7:0] level;
    logic       last;
  } led_write_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic func_i = mlbc_pkg::FUNC_CMD;
  logic [3:0] led_index_i = '0;
  logic [1:0] mode_i = mlbc_pkg::MODE_OFF;
  logic [31:0] now_ms_i = '0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [mlbc_pkg::CFG_IDX_W-1:0] cfg_index_i = mlbc_pkg::CFG_ON_BRIGHT;
  logic [mlbc_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;
  logic result_valid_o;
  logic [3:0] out_led_o;
  logic [7:0] brightness_o;
  logic last_o;

  // Shadow of the channel table and the registers
  mlbc_pkg::led_mode_e chan_mode [LED_COUNT];
  logic [31:0] chan_start [LED_COUNT];
  logic        chan_lit [LED_COUNT];
  logic [7:0]  lit_level = mlbc_pkg::ON_BRIGHT_RST;
  logic [15:0] blink_period = mlbc_pkg::BLINK_PERIOD_RST;

  led_item_t  pending_items [$];
  led_write_t expected_writes [$];
  led_item_t  driven_item;
  int unsigned send_idle_pct = 21;
  int unsigned error_count = 0;
  logic [31:0] sim_ms = '0;

  multi_led_blink_controller #(
    .NUM_LEDS(LED_COUNT)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .func_i        (func_i),
    .led_index_i   (led_index_i),
    .mode_i        (mode_i),
    .now_ms_i      (now_ms_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .result_valid_o(result_valid_o),
    .out_led_o     (out_led_o),
    .brightness_o  (brightness_o),
    .last_o        (last_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Clear the shadow table to its reset state
  initial begin
    for (int ch = 0; ch < LED_COUNT; ch++) begin
      chan_mode[ch] = mlbc_pkg::MODE_OFF;
      chan_start[ch] = '0;
      chan_lit[ch] = 1'b0;
    end
  end

  task automatic report_mismatch(input string msg);
    if (error_count < MAX_ERR_LINES) begin
      $display("ERROR at %0t ns: %s", $time, msg);
    end
    error_count++;
  endtask

  // Apply one accepted word to the shadow table and queue the brightness writes it causes
  function automatic void predict_led_writes(input led_item_t it);
    led_write_t writes [$];
    led_write_t w;
    logic [31:0] elapsed;
    if (it.si_func == mlbc_pkg::FUNC_CMD) begin
      chan_mode[it.led] = it.mode;
      w.led = it.led;
      w.level = (it.mode == mlbc_pkg::MODE_OFF) ? 8'd0 : lit_level;
      w.last = 1'b1;
      if (it.mode == mlbc_pkg::MODE_SINGLE || it.mode == mlbc_pkg::MODE_CONT) begin
        chan_start[it.led] = it.now;
      end
      if (it.mode == mlbc_pkg::MODE_CONT) begin
        chan_lit[it.led] = 1'b1;
      end
      writes.push_back(w);
    end else begin
      for (int ch = 0; ch < LED_COUNT; ch++) begin
        elapsed = it.now - chan_start[ch];
        if (elapsed >= {16'd0, blink_period}) begin
          w.led = 4'(ch);
          w.last = 1'b0;
          if (chan_mode[ch] == mlbc_pkg::MODE_SINGLE) begin
            chan_mode[ch] = mlbc_pkg::MODE_OFF;
            w.level = 8'd0;
            writes.push_back(w);
          end else if (chan_mode[ch] == mlbc_pkg::MODE_CONT) begin
            chan_lit[ch] = ~chan_lit[ch];
            chan_start[ch] = it.now;
            w.level = chan_lit[ch] ? lit_level : 8'd0;
            writes.push_back(w);
          end
        end
      end
      if (writes.size() > 0) begin
        writes[writes.size() - 1].last = 1'b1;
      end
    end
    foreach (writes[i]) begin
      expected_writes.push_back(writes[i]);
    end
  endfunction

  // Advance the time base and build one random word; a few carry an arbitrary time
  function automatic led_item_t random_item();
    led_item_t it;
    int unsigned span;
    span = blink_period + 1;
    it.si_func = ($urandom_range(99) < 40) ? mlbc_pkg::FUNC_SCAN : mlbc_pkg::FUNC_CMD;
    it.led = 4'($urandom_range(15));
    it.mode = mlbc_pkg::led_mode_e'($urandom_range(3));
    if ($urandom_range(99) < 8) begin
      it.now = $urandom();
    end else begin
      if (it.si_func == mlbc_pkg::FUNC_SCAN) begin
        sim_ms = sim_ms + $urandom_range(2 * span, 0);
      end else begin
        sim_ms = sim_ms + $urandom_range(span / 4 + 1, 0);
      end
      it.now = sim_ms;
    end
    return it;
  endfunction

  task automatic push_cmd(input logic [3:0] led, input mlbc_pkg::led_mode_e mode,
                          input logic [31:0] now);
    led_item_t it;
    it.si_func = mlbc_pkg::FUNC_CMD;
    it.led = led;
    it.mode = mode;
    it.now = now;
    pending_items.push_back(it);
  endtask

  task automatic push_scan(input logic [31:0] now);
    led_item_t it;
    it.si_func = mlbc_pkg::FUNC_SCAN;
    it.led = 4'($urandom_range(15));
    it.mode = mlbc_pkg::led_mode_e'($urandom_range(3));
    it.now = now;
    pending_items.push_back(it);
  endtask

  // Write one register and mirror it once the word is taken
  task automatic write_reg(input logic [mlbc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mlbc_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == mlbc_pkg::CFG_ON_BRIGHT) begin
      lit_level = data[7:0];
    end else begin
      blink_period = data;
    end
  endtask

  // Hold until every word is sent, the block is idle and every write has come back
  task automatic wait_drained();
    do @(posedge clk_i);
    while (pending_items.size() != 0 || start || busy || expected_writes.size() != 0);
    repeat (LED_COUNT + 8) @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [7:0] level, input logic [15:0] period,
                           input int unsigned idle_pct, input int unsigned count);
    write_reg(mlbc_pkg::CFG_ON_BRIGHT, {8'($urandom()), level});
    write_reg(mlbc_pkg::CFG_BLINK_PERIOD, period);
    send_idle_pct = idle_pct;
    repeat (count) pending_items.push_back(random_item());
    wait_drained();
  endtask

  // Driver: launch the next word when the port is free, hold it while busy
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        predict_led_writes(driven_item);
      end
      if (!start || !busy) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          driven_item = pending_items.pop_front();
          start <= 1'b1;
          func_i <= driven_item.si_func;
          led_index_i <= driven_item.led;
          mode_i <= driven_item.mode;
          now_ms_i <= driven_item.now;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each strobed write with the oldest expected one
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (expected_writes.size() == 0) begin
        report_mismatch($sformatf("unexpected write led=%0d level=%0d last=%0b",
                                  out_led_o, brightness_o, last_o));
      end else begin
        led_write_t w;
        w = expected_writes.pop_front();
        if (out_led_o !== w.led) begin
          report_mismatch($sformatf("out_led %0d, expected %0d", out_led_o, w.led));
        end
        if (brightness_o !== w.level) begin
          report_mismatch($sformatf("brightness %0d on led %0d, expected %0d",
                                    brightness_o, w.led, w.level));
        end
        if (last_o !== w.last) begin
          report_mismatch($sformatf("last %0b on led %0d, expected %0b",
                                    last_o, w.led, w.last));
        end
      end
    end
  end

  // Stimulus: directed words at reset settings, then random phases over the register range
  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 21;
    push_scan(32'h0000_0000);                     // nothing is blinking yet
    push_cmd(4'd0, mlbc_pkg::MODE_ON, 32'h0000_0000);
    push_cmd(4'd15, mlbc_pkg::MODE_OFF, 32'hFFFF_FFFF);
    push_cmd(4'd15, mlbc_pkg::MODE_SINGLE, 32'hFFFF_FFFF);
    push_cmd(4'd0, mlbc_pkg::MODE_CONT, 32'hFFFF_FF00);
    push_scan(32'h0000_0000);                     // timers not yet due across the wrap
    push_scan(32'h0000_01F3);                     // single blink ends, blink goes dark
    push_scan(32'h0000_01F3);                     // timer just restarted
    for (int ch = 0; ch < LED_COUNT; ch++) begin
      push_cmd(4'(ch), mlbc_pkg::MODE_CONT, 32'd1000);
    end
    push_scan(32'd1500);                          // every channel toggles at once
    wait_drained();

    sim_ms = $urandom();
    run_phase(8'd255, 16'd1, 21, 60);
    sim_ms = 32'hFFFF_0000;
    run_phase(8'd0, 16'hFFFF, 84, 60);
    run_phase(8'($urandom()), 16'd0, 84, 40);
    sim_ms = 32'hFFFF_FF00;
    run_phase(8'($urandom()), 16'($urandom_range(300, 2)), 0, 60);
    run_phase(8'd1, 16'd500, 0, 30);

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/mlbc_pkg.sv
sv/mlbc_ctrl.sv
sv/mlbc_dp.sv
sv/multi_led_blink_controller.sv
sv/mlbc_checker.sv
verif/testbench.sv
